### hdl/imu_sample_accumulate_average_core_macros.svh
`ifndef IMU_SAMPLE_ACCUMULATE_AVERAGE_CORE_MACROS_SVH
`define IMU_SAMPLE_ACCUMULATE_AVERAGE_CORE_MACROS_SVH

// check expr in the same cycle as cond
`define IMU_ACC_ASSERT_IMPLY(label, clk, rst, cond, expr, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (cond) |-> (expr)) \
      else $error(msg);

// check expr in the cycle after cond
`define IMU_ACC_ASSERT_NEXT(label, clk, rst, cond, expr, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (cond) |=> (expr)) \
      else $error(msg);

`endif

### hdl/imu_acc_pkg.sv
package imu_acc_pkg;

   localparam int NUM_CHANNELS       = 6;
   localparam int NUM_AXES           = 3;
   localparam int ADDR_BITS          = 3;
   localparam int COUNT_BITS_DEFAULT = 16;
   localparam int SUM_BITS_DEFAULT   = 32;
   localparam int SCALE_BITS         = 24;
   localparam int RESULT_BITS        = 24;
   localparam int RAW_BITS           = 16;
   localparam int TIME_BITS          = 32;
   localparam int SAMPLES_BITS       = 16;
   localparam int DEN_SHIFT          = 8;
   localparam int CSR_DATA_BITS      = 32;
   localparam int CSR_INDEX_BITS     = 2;
   localparam int REQ_DATA_BITS      = TIME_BITS + NUM_CHANNELS * RAW_BITS;
   localparam int REQ_USER_BITS      = 2;
   localparam int RSP_DATA_BITS      = NUM_CHANNELS * RESULT_BITS + SAMPLES_BITS;
   localparam int RSP_USER_BITS      = 1;

   localparam logic [TIME_BITS-1:0]  INTERVAL_RESET    = 32'd5000;
   localparam logic                  LAYOUT_RESET      = 1'b0;
   localparam logic [SCALE_BITS-1:0] GYRO_SCALE_RESET  = 24'd17853;
   localparam logic [SCALE_BITS-1:0] ACCEL_SCALE_RESET = 24'd40183;

   typedef enum logic [CSR_INDEX_BITS-1:0] {
      CSR_SAMPLE_INTERVAL,
      CSR_BOARD_LAYOUT,
      CSR_GYRO_SCALE,
      CSR_ACCEL_SCALE
   } csr_index_type;

   typedef enum logic {
      MODE_SAMPLE,
      MODE_READOUT
   } mode_type;

   typedef struct packed {
      logic                 rd_en;
      logic [ADDR_BITS-1:0] rd_addr;
      logic                 wr_en;
      logic [ADDR_BITS-1:0] wr_addr;
      logic                 clear_all;
   } mem_ctrl_type;

endpackage

### hdl/imu_acc_sum_mem.sv
module imu_acc_sum_mem
   import imu_acc_pkg::*;
#(
   parameter int SUM_BITS = SUM_BITS_DEFAULT
) (
   input  logic                clock,
   input  logic                reset,
   input  mem_ctrl_type        ctrl,
   input  logic [SUM_BITS-1:0] wr_data,
   output logic [SUM_BITS-1:0] rd_data
);

   logic [SUM_BITS-1:0]     sum_ram [NUM_CHANNELS];
   logic [SUM_BITS-1:0]     rd_data_ff;
   logic                    rd_valid_ff;
   logic [NUM_CHANNELS-1:0] valid_ff;

   always_ff @(posedge clock) begin
      if (ctrl.wr_en) begin
         sum_ram[ctrl.wr_addr] <= wr_data;
      end
      if (ctrl.rd_en) begin
         rd_data_ff <= sum_ram[ctrl.rd_addr];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff    <= '0;
         rd_valid_ff <= 1'b0;
      end else begin
         if (ctrl.clear_all) begin
            valid_ff <= '0;
         end else if (ctrl.wr_en) begin
            valid_ff[ctrl.wr_addr] <= 1'b1;
         end
         if (ctrl.rd_en) begin
            rd_valid_ff <= valid_ff[ctrl.rd_addr];
         end
      end
   end

   assign rd_data = rd_valid_ff ? rd_data_ff : '0;

endmodule

### hdl/imu_acc_scaler.sv
module imu_acc_scaler
   import imu_acc_pkg::*;
#(
   parameter int SUM_BITS   = SUM_BITS_DEFAULT,
   parameter int COUNT_BITS = COUNT_BITS_DEFAULT
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   start,
   input  logic [SUM_BITS-1:0]    sum,
   input  logic                   flip,
   input  logic [SCALE_BITS-1:0]  scale,
   input  logic [COUNT_BITS-1:0]  count,
   output logic                   done,
   output logic [RESULT_BITS-1:0] result
);

   localparam int LO_BITS   = (SUM_BITS + 1) / 2;
   localparam int HI_BITS   = SUM_BITS - LO_BITS;
   localparam int ACC_BITS  = SUM_BITS + SCALE_BITS + 1;
   localparam int NSH_BITS  = ACC_BITS - DEN_SHIFT;
   localparam int QUOT_BITS = RESULT_BITS;
   localparam int NUM_BITS  = (NSH_BITS > COUNT_BITS + QUOT_BITS) ? NSH_BITS
                                                                  : COUNT_BITS + QUOT_BITS;
   localparam int STEP_BITS = $clog2(QUOT_BITS);

   localparam logic [RESULT_BITS-1:0] POS_MAX = {1'b0, {(RESULT_BITS-1){1'b1}}};
   localparam logic [RESULT_BITS-1:0] NEG_MAX = {1'b1, {(RESULT_BITS-1){1'b0}}};

   typedef enum logic [2:0] {
      SC_IDLE,
      SC_MUL_LO,
      SC_MUL_HI,
      SC_ADD,
      SC_CHECK,
      SC_DIV,
      SC_FINISH
   } scaler_state_type;

   scaler_state_type             state_ff, state_in;
   logic                         done_ff, done_in;
   logic [RESULT_BITS-1:0]       result_ff, result_in;
   logic                         neg_ff, neg_in;
   logic [SUM_BITS-1:0]          mag_ff, mag_in;
   logic [SCALE_BITS-1:0]        scale_ff, scale_in;
   logic [COUNT_BITS-1:0]        count_ff, count_in;
   logic [LO_BITS+SCALE_BITS-1:0] pp_lo_ff, pp_lo_in;
   logic [HI_BITS+SCALE_BITS-1:0] pp_hi_ff, pp_hi_in;
   logic [NUM_BITS-1:0]          num_ff, num_in;
   logic [COUNT_BITS-1:0]        rem_ff, rem_in;
   logic [QUOT_BITS-1:0]         quot_ff, quot_in;
   logic [STEP_BITS-1:0]         step_ff, step_in;
   logic                         sat_ff, sat_in;

   logic [ACC_BITS-1:0]          acc_sum;
   logic [NUM_BITS-1:0]          limit;
   logic [COUNT_BITS:0]          trial;
   logic [COUNT_BITS:0]          trial_diff;
   logic                         qbit;

   always_comb begin
      state_in  = state_ff;
      done_in   = 1'b0;
      result_in = result_ff;
      neg_in    = neg_ff;
      mag_in    = mag_ff;
      scale_in  = scale_ff;
      count_in  = count_ff;
      pp_lo_in  = pp_lo_ff;
      pp_hi_in  = pp_hi_ff;
      num_in    = num_ff;
      rem_in    = rem_ff;
      quot_in   = quot_ff;
      step_in   = step_ff;
      sat_in    = sat_ff;

      acc_sum = ACC_BITS'({pp_hi_ff, {LO_BITS{1'b0}}}) + ACC_BITS'(pp_lo_ff)
              + (ACC_BITS'(count_ff) << (DEN_SHIFT - 1));
      limit      = NUM_BITS'(count_ff) << QUOT_BITS;
      trial      = {rem_ff, quot_ff[QUOT_BITS-1]};
      trial_diff = trial - {1'b0, count_ff};
      qbit       = (trial >= {1'b0, count_ff});

      case (state_ff)
         SC_IDLE: begin
            if (start) begin
               neg_in   = sum[SUM_BITS-1] ^ flip;
               mag_in   = sum[SUM_BITS-1] ? SUM_BITS'(~sum + SUM_BITS'(1)) : sum;
               scale_in = scale;
               count_in = count;
               state_in = SC_MUL_LO;
            end
         end
         SC_MUL_LO: begin
            pp_lo_in = mag_ff[LO_BITS-1:0] * scale_ff;
            state_in = SC_MUL_HI;
         end
         SC_MUL_HI: begin
            pp_hi_in = mag_ff[SUM_BITS-1:LO_BITS] * scale_ff;
            state_in = SC_ADD;
         end
         SC_ADD: begin
            num_in   = NUM_BITS'(acc_sum[ACC_BITS-1:DEN_SHIFT]);
            state_in = SC_CHECK;
         end
         SC_CHECK: begin
            if (num_ff >= limit) begin
               sat_in   = 1'b1;
               state_in = SC_FINISH;
            end else begin
               sat_in   = 1'b0;
               rem_in   = num_ff[QUOT_BITS +: COUNT_BITS];
               quot_in  = num_ff[QUOT_BITS-1:0];
               step_in  = '0;
               state_in = SC_DIV;
            end
         end
         SC_DIV: begin
            rem_in  = qbit ? trial_diff[COUNT_BITS-1:0] : trial[COUNT_BITS-1:0];
            quot_in = {quot_ff[QUOT_BITS-2:0], qbit};
            step_in = step_ff + 1'b1;
            if (step_ff == STEP_BITS'(QUOT_BITS - 1)) begin
               state_in = SC_FINISH;
            end
         end
         SC_FINISH: begin
            done_in = 1'b1;
            if (neg_ff) begin
               result_in = (sat_ff || quot_ff > NEG_MAX) ? NEG_MAX
                                                        : RESULT_BITS'(~quot_ff + 1'b1);
            end else begin
               result_in = (sat_ff || quot_ff[QUOT_BITS-1]) ? POS_MAX : quot_ff;
            end
            state_in = SC_IDLE;
         end
         default: begin
            state_in = SC_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      result_ff <= result_in;
      neg_ff    <= neg_in;
      mag_ff    <= mag_in;
      scale_ff  <= scale_in;
      count_ff  <= count_in;
      pp_lo_ff  <= pp_lo_in;
      pp_hi_ff  <= pp_hi_in;
      num_ff    <= num_in;
      rem_ff    <= rem_in;
      quot_ff   <= quot_in;
      step_ff   <= step_in;
      sat_ff    <= sat_in;
      if (reset) begin
         state_ff <= SC_IDLE;
         done_ff  <= 1'b0;
      end else begin
         state_ff <= state_in;
         done_ff  <= done_in;
      end
   end

   assign done   = done_ff;
   assign result = result_ff;

endmodule

### hdl/imu_sample_accumulate_average_core.sv
// Six-channel inertial sample accumulator with scaled averaging readout.
// req channel: one word per item. A sample word (mode 0) is rate limited by its
// time stamp against the programmed interval; a passing sample updates the stored
// time and, unless its read-failed flag is set, is added into six running sums.
// A readout word (mode 1) produces one rsp word with the six scaled averages and
// the sample count, then clears the sums and the count.
// A dropped or failed sample leaves req_tready high; an accumulated sample keeps
// req_tready low while the sum memory is read, updated and written back one
// channel per cycle. A readout scales each channel in turn by one memory read,
// a hand-off, two partial-product multiplies, an add, a range check, a 24-step
// restoring divide by the sample count and a finish step (the divide is skipped
// when the quotient saturates).
// An empty readout skips the scaling and answers with no_data set.
// The finished word sits in an output register; the next req word is taken while
// it waits, but a later readout holds in its final state until rsp_tready frees it.
// Reset: sums and count empty, stored time zero, registers at defaults; the
// csr port takes writes at any time and has no read-back.
`include "imu_sample_accumulate_average_core_macros.svh"

module imu_sample_accumulate_average_core
   import imu_acc_pkg::*;
#(
   parameter int COUNT_BITS = COUNT_BITS_DEFAULT,
   parameter int SUM_BITS   = SUM_BITS_DEFAULT
) (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      csr_we,
   input  logic [CSR_INDEX_BITS-1:0] csr_index,
   input  logic [CSR_DATA_BITS-1:0]  csr_wdata,
   input  logic                      req_tvalid,
   output logic                      req_tready,
   // now_us, accel_x_raw, accel_y_raw, accel_z_raw, gyro_x_raw, gyro_y_raw, gyro_z_raw
   input  logic [REQ_DATA_BITS-1:0]  req_tdata,
   // mode, read_failed
   input  logic [REQ_USER_BITS-1:0]  req_tuser,
   output logic                      rsp_tvalid,
   input  logic                      rsp_tready,
   // rate_x, rate_y, rate_z, accel_x, accel_y, accel_z, samples_averaged
   output logic [RSP_DATA_BITS-1:0]  rsp_tdata,
   // no_data
   output logic [RSP_USER_BITS-1:0]  rsp_tuser
);

   localparam int CNT_EXT_BITS = (COUNT_BITS > SAMPLES_BITS) ? COUNT_BITS : SAMPLES_BITS;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_ACC,
      ST_RD_ADDR,
      ST_RD_DATA,
      ST_SCALE,
      ST_FIN
   } state_type;

   state_type               state_ff, state_in;
   logic [ADDR_BITS-1:0]    idx_ff, idx_in;
   logic [COUNT_BITS-1:0]   count_ff, count_in;
   logic [TIME_BITS-1:0]    last_time_ff, last_time_in;
   logic [TIME_BITS-1:0]    interval_ff, interval_in;
   logic                    layout_ff, layout_in;
   logic [SCALE_BITS-1:0]   gyro_scale_ff, gyro_scale_in;
   logic [SCALE_BITS-1:0]   accel_scale_ff, accel_scale_in;
   logic                    nodata_ff, nodata_in;
   logic                    rsp_tvalid_ff, rsp_tvalid_in;

   logic [RAW_BITS-1:0]      smp_ff [NUM_CHANNELS];
   logic [RAW_BITS-1:0]      smp_in [NUM_CHANNELS];
   logic [RESULT_BITS-1:0]   res_ff [NUM_CHANNELS];
   logic [RESULT_BITS-1:0]   res_in [NUM_CHANNELS];
   logic [RSP_DATA_BITS-1:0] rsp_tdata_ff, rsp_tdata_in;
   logic [RSP_USER_BITS-1:0] rsp_tuser_ff, rsp_tuser_in;

   mem_ctrl_type            mem_ctrl;
   logic [SUM_BITS-1:0]     mem_wr_data;
   logic [SUM_BITS-1:0]     mem_rd_data;

   logic                    scale_start;
   logic                    scale_done;
   logic [RESULT_BITS-1:0]  scale_result;
   logic                    chan_flip_sel;
   logic [SCALE_BITS-1:0]   chan_scale_sel;

   logic                    req_accept;
   logic [TIME_BITS-1:0]    elapsed;
   logic                    gate_pass;
   logic [ADDR_BITS-1:0]    wr_idx;
   logic [RAW_BITS-1:0]     smp_sel;
   logic [COUNT_BITS-1:0]   count_next;
   logic                    out_free;
   logic                    out_load;
   logic [CNT_EXT_BITS-1:0] count_ext;
   logic [SAMPLES_BITS-1:0] samples_sat;
   logic [RSP_DATA_BITS-1:0] rsp_packed;

   function automatic logic [ADDR_BITS-1:0] chan_lane(input logic [ADDR_BITS-1:0] j);
      return (j < ADDR_BITS'(NUM_AXES)) ? j : ADDR_BITS'(j - ADDR_BITS'(NUM_AXES));
   endfunction

   function automatic logic [ADDR_BITS-1:0] chan_addr(input logic [ADDR_BITS-1:0] j,
                                                      input logic layout);
      logic [ADDR_BITS-1:0] base;
      logic [ADDR_BITS-1:0] lane;
      logic [ADDR_BITS-1:0] pick;
      base = (j < ADDR_BITS'(NUM_AXES)) ? ADDR_BITS'(NUM_AXES) : '0;
      lane = chan_lane(j);
      case (lane)
         ADDR_BITS'(0): pick = layout ? ADDR_BITS'(1) : ADDR_BITS'(0);
         ADDR_BITS'(1): pick = layout ? ADDR_BITS'(0) : ADDR_BITS'(1);
         default:       pick = ADDR_BITS'(2);
      endcase
      return base + pick;
   endfunction

   function automatic logic chan_flip(input logic [ADDR_BITS-1:0] j, input logic layout);
      logic [ADDR_BITS-1:0] lane;
      lane = chan_lane(j);
      return (lane == ADDR_BITS'(0)) ? !layout : (lane == ADDR_BITS'(2));
   endfunction

   imu_acc_sum_mem #(
      .SUM_BITS (SUM_BITS)
   ) u_sum_mem (
      .clock   (clock),
      .reset   (reset),
      .ctrl    (mem_ctrl),
      .wr_data (mem_wr_data),
      .rd_data (mem_rd_data)
   );

   imu_acc_scaler #(
      .SUM_BITS   (SUM_BITS),
      .COUNT_BITS (COUNT_BITS)
   ) u_scaler (
      .clock  (clock),
      .reset  (reset),
      .start  (scale_start),
      .sum    (mem_rd_data),
      .flip   (chan_flip_sel),
      .scale  (chan_scale_sel),
      .count  (count_ff),
      .done   (scale_done),
      .result (scale_result)
   );

   assign req_tready = (state_ff == ST_IDLE);
   assign req_accept = req_tvalid && req_tready;
   assign elapsed    = req_tdata[TIME_BITS-1:0] - last_time_ff;
   assign gate_pass  = (elapsed >= interval_ff);
   assign wr_idx     = ADDR_BITS'(idx_ff - 1'b1);
   assign smp_sel    = smp_ff[wr_idx];
   assign count_next = COUNT_BITS'(count_ff + 1'b1);
   assign out_free   = !rsp_tvalid_ff || rsp_tready;
   assign out_load   = (state_ff == ST_FIN) && out_free;
   assign mem_wr_data = mem_rd_data + {{(SUM_BITS-RAW_BITS){smp_sel[RAW_BITS-1]}}, smp_sel};
   assign chan_flip_sel  = chan_flip(idx_ff, layout_ff);
   assign chan_scale_sel = (idx_ff < ADDR_BITS'(NUM_AXES)) ? gyro_scale_ff : accel_scale_ff;

   assign count_ext   = CNT_EXT_BITS'(count_ff);
   assign samples_sat = (count_ext > CNT_EXT_BITS'({SAMPLES_BITS{1'b1}}))
                        ? {SAMPLES_BITS{1'b1}} : count_ext[SAMPLES_BITS-1:0];
   assign rsp_packed  = nodata_ff ? '0
                        : {samples_sat, res_ff[5], res_ff[4], res_ff[3],
                           res_ff[2], res_ff[1], res_ff[0]};

   always_comb begin
      state_in       = state_ff;
      idx_in         = idx_ff;
      count_in       = count_ff;
      last_time_in   = last_time_ff;
      interval_in    = interval_ff;
      layout_in      = layout_ff;
      gyro_scale_in  = gyro_scale_ff;
      accel_scale_in = accel_scale_ff;
      nodata_in      = nodata_ff;
      smp_in         = smp_ff;
      res_in         = res_ff;
      mem_ctrl       = '0;
      scale_start    = 1'b0;

      if (csr_we) begin
         case (csr_index_type'(csr_index))
            CSR_SAMPLE_INTERVAL: interval_in    = csr_wdata[TIME_BITS-1:0];
            CSR_BOARD_LAYOUT:    layout_in      = csr_wdata[0];
            CSR_GYRO_SCALE:      gyro_scale_in  = csr_wdata[SCALE_BITS-1:0];
            CSR_ACCEL_SCALE:     accel_scale_in = csr_wdata[SCALE_BITS-1:0];
            default: ;
         endcase
      end

      case (state_ff)
         ST_IDLE: begin
            if (req_accept) begin
               for (int c = 0; c < NUM_CHANNELS; c++) begin
                  smp_in[c] = req_tdata[TIME_BITS + c*RAW_BITS +: RAW_BITS];
               end
               if (mode_type'(req_tuser[0]) == MODE_READOUT) begin
                  idx_in = '0;
                  if (count_ff == '0) begin
                     nodata_in = 1'b1;
                     state_in  = ST_FIN;
                  end else begin
                     nodata_in = 1'b0;
                     state_in  = ST_RD_ADDR;
                  end
               end else if (gate_pass) begin
                  last_time_in = req_tdata[TIME_BITS-1:0];
                  if (!req_tuser[1]) begin
                     idx_in   = '0;
                     state_in = ST_ACC;
                  end
               end
            end
         end
         ST_ACC: begin
            if (idx_ff < ADDR_BITS'(NUM_CHANNELS)) begin
               mem_ctrl.rd_en   = 1'b1;
               mem_ctrl.rd_addr = idx_ff;
            end
            if (idx_ff != '0) begin
               mem_ctrl.wr_en   = 1'b1;
               mem_ctrl.wr_addr = wr_idx;
            end
            idx_in = ADDR_BITS'(idx_ff + 1'b1);
            if (idx_ff == ADDR_BITS'(NUM_CHANNELS)) begin
               count_in = count_next;
               if (count_next == '0) begin
                  mem_ctrl.clear_all = 1'b1;
               end
               state_in = ST_IDLE;
            end
         end
         ST_RD_ADDR: begin
            mem_ctrl.rd_en   = 1'b1;
            mem_ctrl.rd_addr = chan_addr(idx_ff, layout_ff);
            state_in         = ST_RD_DATA;
         end
         ST_RD_DATA: begin
            scale_start = 1'b1;
            state_in    = ST_SCALE;
         end
         ST_SCALE: begin
            if (scale_done) begin
               res_in[idx_ff] = scale_result;
               if (idx_ff == ADDR_BITS'(NUM_CHANNELS - 1)) begin
                  state_in = ST_FIN;
               end else begin
                  idx_in   = ADDR_BITS'(idx_ff + 1'b1);
                  state_in = ST_RD_ADDR;
               end
            end
         end
         ST_FIN: begin
            if (out_free) begin
               mem_ctrl.clear_all = 1'b1;
               count_in           = '0;
               state_in           = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase

      rsp_tvalid_in = out_load ? 1'b1 : (rsp_tready ? 1'b0 : rsp_tvalid_ff);
      rsp_tdata_in  = out_load ? rsp_packed : rsp_tdata_ff;
      rsp_tuser_in  = out_load ? RSP_USER_BITS'(nodata_ff) : rsp_tuser_ff;
   end

   always_ff @(posedge clock) begin
      smp_ff       <= smp_in;
      res_ff       <= res_in;
      rsp_tdata_ff <= rsp_tdata_in;
      rsp_tuser_ff <= rsp_tuser_in;
      if (reset) begin
         state_ff       <= ST_IDLE;
         idx_ff         <= '0;
         count_ff       <= '0;
         last_time_ff   <= '0;
         interval_ff    <= INTERVAL_RESET;
         layout_ff      <= LAYOUT_RESET;
         gyro_scale_ff  <= GYRO_SCALE_RESET;
         accel_scale_ff <= ACCEL_SCALE_RESET;
         nodata_ff      <= 1'b0;
         rsp_tvalid_ff  <= 1'b0;
      end else begin
         state_ff       <= state_in;
         idx_ff         <= idx_in;
         count_ff       <= count_in;
         last_time_ff   <= last_time_in;
         interval_ff    <= interval_in;
         layout_ff      <= layout_in;
         gyro_scale_ff  <= gyro_scale_in;
         accel_scale_ff <= accel_scale_in;
         nodata_ff      <= nodata_in;
         rsp_tvalid_ff  <= rsp_tvalid_in;
      end
   end

   assign rsp_tvalid = rsp_tvalid_ff;
   assign rsp_tdata  = rsp_tdata_ff;
   assign rsp_tuser  = rsp_tuser_ff;

   `IMU_ACC_ASSERT_NEXT(a_readout_starts, clock, reset, req_accept && req_tuser[0], state_ff == ST_RD_ADDR || state_ff == ST_FIN, "readout word did not start a readout")
   `IMU_ACC_ASSERT_NEXT(a_load_clears, clock, reset, out_load, rsp_tvalid_ff && count_ff == '0, "readout load did not clear the count")
   `IMU_ACC_ASSERT_IMPLY(a_done_in_wait, clock, reset, scale_done, state_ff == ST_SCALE, "scaler finished outside its wait state")

endmodule

### test/imu_sample_accumulate_average_core_test.sv
`timescale 1ns / 100ps

module imu_sample_accumulate_average_core_test
   import imu_acc_pkg::*;
;

   localparam int SUM_W          = SUM_BITS_DEFAULT;
   localparam int COUNT_W        = COUNT_BITS_DEFAULT;
   localparam int WATCHDOG_LIMIT = 20000;
   localparam int SETTLE_CYCLES  = 20;
   localparam int END_CYCLES     = 250;
   localparam int HOLD_CYCLES    = 3000;
   localparam int RANDOM_PHASES  = 5;
   localparam int PHASE_ITEMS    = 100;
   localparam logic [CSR_DATA_BITS-1:0] SCALE_MAX    = (1 << SCALE_BITS) - 1;
   localparam logic [CSR_DATA_BITS-1:0] INTERVAL_MAX = '1;

   typedef struct packed {
      logic                                   no_data;
      logic [NUM_CHANNELS-1:0][RESULT_BITS-1:0] value;
      logic [SAMPLES_BITS-1:0]                samples;
   } average_word;

   class average_tracker;
      logic [SUM_W-1:0]      sums [NUM_CHANNELS];
      logic [COUNT_W-1:0]    count;
      logic [TIME_BITS-1:0]  last_time;
      logic [TIME_BITS-1:0]  interval;
      logic                  layout;
      logic [SCALE_BITS-1:0] gyro_scale;
      logic [SCALE_BITS-1:0] accel_scale;
      average_word           pending_averages [$];
      int                    error_count;
      string                 value_name [NUM_CHANNELS];

      function new();
         value_name = '{"rate_x", "rate_y", "rate_z", "accel_x", "accel_y", "accel_z"};
         foreach (sums[c]) sums[c] = '0;
         count       = '0;
         last_time   = '0;
         interval    = INTERVAL_RESET;
         layout      = LAYOUT_RESET;
         gyro_scale  = GYRO_SCALE_RESET;
         accel_scale = ACCEL_SCALE_RESET;
         error_count = 0;
      endfunction

      function void set_reg(csr_index_type idx, logic [CSR_DATA_BITS-1:0] value);
         case (idx)
            CSR_SAMPLE_INTERVAL: interval = value[TIME_BITS-1:0];
            CSR_BOARD_LAYOUT:    layout = value[0];
            CSR_GYRO_SCALE:      gyro_scale = value[SCALE_BITS-1:0];
            CSR_ACCEL_SCALE:     accel_scale = value[SCALE_BITS-1:0];
            default: ;
         endcase
      endfunction

      function logic [RESULT_BITS-1:0] scaled_mean(logic [SUM_W-1:0] sum, logic flip,
                                                   logic [SCALE_BITS-1:0] scale,
                                                   logic [COUNT_W-1:0] n);
         logic             neg;
         logic [SUM_W-1:0] abs_sum;
         logic [63:0]      mag;
         logic [63:0]      den;
         logic [63:0]      quo;
         neg     = sum[SUM_W-1];
         abs_sum = neg ? -sum : sum;
         mag     = 64'(abs_sum);
         neg     = neg ^ flip;
         mag     = mag * scale;
         den     = 64'(n);
         den     = den << DEN_SHIFT;
         quo     = (mag + (den >> 1)) / den;
         if (neg) begin
            if (quo > (64'd1 << (RESULT_BITS - 1))) quo = 64'd1 << (RESULT_BITS - 1);
            quo = -quo;
         end else if (quo > (64'd1 << (RESULT_BITS - 1)) - 1) begin
            quo = (64'd1 << (RESULT_BITS - 1)) - 1;
         end
         return quo[RESULT_BITS-1:0];
      endfunction

      function void take_word(mode_type mode, logic failed, logic [REQ_DATA_BITS-1:0] data);
         average_word          avg;
         logic [TIME_BITS-1:0] now;
         logic [TIME_BITS-1:0] elapsed;
         logic [RAW_BITS-1:0]  raw;
         int                   ix;
         int                   iy;
         logic                 fx;
         if (mode == MODE_SAMPLE) begin
            now     = data[TIME_BITS-1:0];
            elapsed = now - last_time;
            if (elapsed < interval) return;
            last_time = now;
            if (failed) return;
            for (int c = 0; c < NUM_CHANNELS; c++) begin
               raw     = data[TIME_BITS + c*RAW_BITS +: RAW_BITS];
               sums[c] = sums[c] + {{(SUM_W-RAW_BITS){raw[RAW_BITS-1]}}, raw};
            end
            count = count + 1'b1;
            if (count == 0) begin
               foreach (sums[c]) sums[c] = '0;
            end
            return;
         end
         avg = '0;
         if (count == 0) begin
            avg.no_data = 1'b1;
         end else begin
            ix = layout ? 1 : 0;
            iy = layout ? 0 : 1;
            fx = !layout;
            avg.value[0] = scaled_mean(sums[NUM_AXES + ix], fx, gyro_scale, count);
            avg.value[1] = scaled_mean(sums[NUM_AXES + iy], 1'b0, gyro_scale, count);
            avg.value[2] = scaled_mean(sums[NUM_AXES + 2], 1'b1, gyro_scale, count);
            avg.value[3] = scaled_mean(sums[ix], fx, accel_scale, count);
            avg.value[4] = scaled_mean(sums[iy], 1'b0, accel_scale, count);
            avg.value[5] = scaled_mean(sums[2], 1'b1, accel_scale, count);
            avg.samples  = count;
         end
         pending_averages.push_back(avg);
         foreach (sums[c]) sums[c] = '0;
         count = '0;
      endfunction

      task report_mismatch(string what);
         error_count++;
         $display("mismatch at %0t: %s", $time, what);
      endtask

      task match_result(logic [RSP_USER_BITS-1:0] user, logic [RSP_DATA_BITS-1:0] data);
         average_word want;
         if (pending_averages.size() == 0) begin
            report_mismatch("result word with no readout pending");
            return;
         end
         want = pending_averages.pop_front();
         if (user[0] !== want.no_data)
            report_mismatch($sformatf("no_data got %0b want %0b", user[0], want.no_data));
         for (int i = 0; i < NUM_CHANNELS; i++) begin
            if (data[i*RESULT_BITS +: RESULT_BITS] !== want.value[i])
               report_mismatch($sformatf("%s got %h want %h", value_name[i],
                                         data[i*RESULT_BITS +: RESULT_BITS], want.value[i]));
         end
         if (data[NUM_CHANNELS*RESULT_BITS +: SAMPLES_BITS] !== want.samples)
            report_mismatch($sformatf("samples_averaged got %0d want %0d",
                                      data[NUM_CHANNELS*RESULT_BITS +: SAMPLES_BITS],
                                      want.samples));
      endtask
   endclass

   logic                      clock;
   logic                      reset;
   logic                      csr_we;
   logic [CSR_INDEX_BITS-1:0] csr_index;
   logic [CSR_DATA_BITS-1:0]  csr_wdata;
   logic                      req_tvalid;
   logic                      req_tready;
   // now_us, accel_x_raw, accel_y_raw, accel_z_raw, gyro_x_raw, gyro_y_raw, gyro_z_raw
   logic [REQ_DATA_BITS-1:0]  req_tdata;
   // mode, read_failed
   logic [REQ_USER_BITS-1:0]  req_tuser;
   logic                      rsp_tvalid;
   logic                      rsp_tready;
   // rate_x, rate_y, rate_z, accel_x, accel_y, accel_z, samples_averaged
   logic [RSP_DATA_BITS-1:0]  rsp_tdata;
   // no_data
   logic [RSP_USER_BITS-1:0]  rsp_tuser;

   bit rsp_hold_req    = 1'b0;
   bit rsp_hold_active = 1'b0;
   int idle_cycles;

   average_tracker tracker = new();

   imu_sample_accumulate_average_core DUT (.*);

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   function automatic logic [REQ_DATA_BITS-1:0] pack_sample(
      logic [TIME_BITS-1:0] now, int ax, int ay, int az, int gx, int gy, int gz);
      return {RAW_BITS'(gz), RAW_BITS'(gy), RAW_BITS'(gx),
              RAW_BITS'(az), RAW_BITS'(ay), RAW_BITS'(ax), now};
   endfunction

   function automatic logic [RAW_BITS-1:0] raw_value();
      case ($urandom_range(0, 15))
         0: return 16'h8000;
         1: return 16'h7FFF;
         2: return 16'hFFFF;
         3: return 16'h0000;
         default: return RAW_BITS'($urandom);
      endcase
   endfunction

   task send_word(input mode_type mode, input logic failed,
                  input logic [REQ_DATA_BITS-1:0] data);
      @(negedge clock);
      req_tvalid = 1'b1;
      req_tuser  = {failed, mode};
      req_tdata  = data;
      do @(posedge clock); while (!req_tready);
      tracker.take_word(mode, failed, data);
   endtask

   task pace_sender();
      int unsigned pick;
      int unsigned gap;
      pick = $urandom_range(0, 99);
      if (pick < 60) gap = 0;
      else if (pick < 95) gap = $urandom_range(1, 3);
      else gap = $urandom_range(20, 100);
      if (gap > 0) begin
         @(negedge clock);
         req_tvalid = 1'b0;
         repeat (gap - 1) @(negedge clock);
      end
   endtask

   task settle_block();
      @(negedge clock);
      req_tvalid = 1'b0;
      while (tracker.pending_averages.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task write_reg(input csr_index_type idx, input logic [CSR_DATA_BITS-1:0] value);
      settle_block();
      @(negedge clock);
      csr_we    = 1'b1;
      csr_index = idx;
      csr_wdata = value;
      tracker.set_reg(idx, value);
      @(negedge clock);
      csr_we = 1'b0;
   endtask

   task send_random_item();
      int unsigned               pick;
      logic [TIME_BITS-1:0]      now;
      logic [REQ_DATA_BITS-1:0]  data;
      data = {$urandom, $urandom, $urandom, $urandom};
      for (int c = 0; c < NUM_CHANNELS; c++)
         data[TIME_BITS + c*RAW_BITS +: RAW_BITS] = raw_value();
      pick = $urandom_range(0, 99);
      if (pick < 15) begin
         send_word(MODE_READOUT, 1'($urandom_range(0, 1)), data);
      end else begin
         pick = $urandom_range(0, 99);
         if (pick < 70)
            now = tracker.last_time + tracker.interval +
                  ($urandom_range(0, 1) ? 0 : $urandom_range(1, 3));
         else if (pick < 85)
            now = tracker.last_time + tracker.interval - 1 - $urandom_range(0, 2);
         else
            now = $urandom;
         data[TIME_BITS-1:0] = now;
         send_word(MODE_SAMPLE, $urandom_range(0, 9) == 0, data);
      end
      pace_sender();
   endtask

   // receiver: random backpressure, plus one long hold on request
   initial begin
      int unsigned pick;
      int unsigned span;
      rsp_tready = 1'b0;
      forever begin
         if (rsp_hold_req) begin
            rsp_hold_active = 1'b1;
            rsp_tready      = 1'b0;
            repeat (HOLD_CYCLES) @(negedge clock);
            rsp_hold_req    = 1'b0;
            rsp_hold_active = 1'b0;
         end else begin
            pick = $urandom_range(0, 99);
            if (pick < 75) begin
               rsp_tready = 1'b1;
               span = $urandom_range(1, 8);
            end else begin
               rsp_tready = 1'b0;
               span = ($urandom_range(0, 9) == 0) ? $urandom_range(30, 150)
                                                  : $urandom_range(1, 3);
            end
            repeat (span) @(negedge clock);
         end
      end
   end

   always @(posedge clock) begin
      if (!reset && rsp_tvalid && rsp_tready) tracker.match_result(rsp_tuser, rsp_tdata);
   end

   initial begin
      idle_cycles = 0;
      while (idle_cycles < WATCHDOG_LIMIT) begin
         @(posedge clock);
         if ((req_tvalid && req_tready) || (rsp_tvalid && rsp_tready) || csr_we || reset)
            idle_cycles = 0;
         else
            idle_cycles++;
      end
      $display("FAIL");
      $finish;
   end

   initial begin
      logic [REQ_DATA_BITS-1:0] burst_word;
      reset      = 1'b1;
      csr_we     = 1'b0;
      csr_index  = CSR_SAMPLE_INTERVAL;
      csr_wdata  = '0;
      req_tvalid = 1'b0;
      req_tdata  = '0;
      req_tuser  = '0;
      repeat (8) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // directed, reset register values first
      send_word(MODE_READOUT, 1'b0, '0);
      send_word(MODE_SAMPLE, 1'b0, pack_sample(32'd4999, 1, 2, 3, 4, 5, 6));
      send_word(MODE_SAMPLE, 1'b0,
                pack_sample(32'd5000, 16'h7FFF, 16'h8000, 1000, 16'hFFFF, 0, 12345));
      send_word(MODE_SAMPLE, 1'b1, pack_sample(32'd10000, 100, 100, 100, 100, 100, 100));
      send_word(MODE_SAMPLE, 1'b0, pack_sample(32'd14999, 7, 7, 7, 7, 7, 7));
      send_word(MODE_SAMPLE, 1'b0,
                pack_sample(32'd15000, 16'h8000, 16'h7FFF, -16'sd5, 16'h7FFF, 16'h8000, 3));
      send_word(MODE_READOUT, 1'b0, '0);
      send_word(MODE_READOUT, 1'b0, '0);
      send_word(MODE_SAMPLE, 1'b0,
                pack_sample(32'd20000, 300, -16'sd301, 9001, -16'sd77, 1234, -16'sd4321));
      send_word(MODE_READOUT, 1'b0, '1);

      write_reg(CSR_SAMPLE_INTERVAL, '0);
      write_reg(CSR_BOARD_LAYOUT, 1);
      write_reg(CSR_GYRO_SCALE, SCALE_MAX);
      write_reg(CSR_ACCEL_SCALE, SCALE_MAX);
      send_word(MODE_SAMPLE, 1'b0, pack_sample(32'd0, 16'h8000, 16'h7FFF, 16'h8000,
                                               16'h7FFF, 16'h8000, 16'h7FFF));
      send_word(MODE_READOUT, 1'b0, '0);
      send_word(MODE_SAMPLE, 1'b0, pack_sample(32'd1, 16'h7FFF, 16'h8000, 16'h7FFF,
                                               16'h8000, 16'h7FFF, 16'h8000));
      send_word(MODE_READOUT, 1'b0, '0);

      write_reg(CSR_SAMPLE_INTERVAL, INTERVAL_MAX);
      write_reg(CSR_GYRO_SCALE, '0);
      write_reg(CSR_ACCEL_SCALE, '0);
      send_word(MODE_SAMPLE, 1'b0, pack_sample(32'd0, 11, 22, 33, 44, 55, 66));
      send_word(MODE_SAMPLE, 1'b0, pack_sample(32'hFFFFFFFF, 11, 22, 33, 44, 55, 66));
      send_word(MODE_READOUT, 1'b0, '0);

      // time stamp wrap across zero
      write_reg(CSR_SAMPLE_INTERVAL, 100);
      write_reg(CSR_BOARD_LAYOUT, 0);
      write_reg(CSR_GYRO_SCALE, GYRO_SCALE_RESET);
      write_reg(CSR_ACCEL_SCALE, ACCEL_SCALE_RESET);
      send_word(MODE_SAMPLE, 1'b0, pack_sample(32'hFFFFFFF0, 9, 8, 7, 6, 5, 4));
      send_word(MODE_SAMPLE, 1'b0, pack_sample(32'h00000050, 1, 1, 1, 1, 1, 1));
      send_word(MODE_SAMPLE, 1'b0, pack_sample(32'h00000054, 16'h8000, 2, 3, 4, 5, 16'h7FFF));
      send_word(MODE_READOUT, 1'b0, '0);
      send_word(MODE_READOUT, 1'b1, {$urandom, $urandom, $urandom, $urandom});

      for (int phase = 0; phase < RANDOM_PHASES; phase++) begin
         case (phase)
            0: begin
               write_reg(CSR_SAMPLE_INTERVAL, '0);
               write_reg(CSR_BOARD_LAYOUT, 0);
               write_reg(CSR_GYRO_SCALE, $urandom & SCALE_MAX);
               write_reg(CSR_ACCEL_SCALE, $urandom & SCALE_MAX);
            end
            1: begin
               write_reg(CSR_SAMPLE_INTERVAL, $urandom_range(1, 50));
               write_reg(CSR_BOARD_LAYOUT, 1);
               write_reg(CSR_GYRO_SCALE, SCALE_MAX);
               write_reg(CSR_ACCEL_SCALE, '0);
            end
            2: begin
               write_reg(CSR_SAMPLE_INTERVAL, INTERVAL_MAX);
               write_reg(CSR_BOARD_LAYOUT, $urandom_range(0, 1));
               write_reg(CSR_GYRO_SCALE, $urandom & SCALE_MAX);
               write_reg(CSR_ACCEL_SCALE, $urandom & SCALE_MAX);
            end
            3: begin
               write_reg(CSR_SAMPLE_INTERVAL, INTERVAL_RESET);
               write_reg(CSR_BOARD_LAYOUT, 0);
               write_reg(CSR_GYRO_SCALE, '0);
               write_reg(CSR_ACCEL_SCALE, SCALE_MAX);
            end
            default: begin
               write_reg(CSR_SAMPLE_INTERVAL, $urandom);
               write_reg(CSR_BOARD_LAYOUT, 1);
               write_reg(CSR_GYRO_SCALE, $urandom_range(0, 255));
               write_reg(CSR_ACCEL_SCALE, $urandom & SCALE_MAX);
            end
         endcase
         for (int n = 0; n < PHASE_ITEMS; n++) begin
            if (phase == 0 && n == PHASE_ITEMS / 2) begin
               // hold the result side off and keep offering words until input stalls
               rsp_hold_req = 1'b1;
               wait (rsp_hold_active);
               for (int k = 0; k < 12; k++) begin
                  burst_word = {$urandom, $urandom, $urandom, $urandom};
                  send_word((k % 2) ? MODE_SAMPLE : MODE_READOUT, 1'b0, burst_word);
               end
            end
            if (phase == 1 && n == PHASE_ITEMS / 2) settle_block();
            send_random_item();
         end
      end

      settle_block();
      repeat (END_CYCLES) @(posedge clock);
      if (tracker.error_count == 0) begin
         $display("PASS");
      end else begin
         $display("FAIL");
      end
      $finish;
   end

endmodule
